[src/rosrch_pkg.sv]
// ----------------------------------------------------------------------------
// rosrch_pkg
// Shared types, operation and result codes, and the CRC-8 step used by the
// ROM search engine.
// ----------------------------------------------------------------------------
package rosrch_pkg;

    localparam logic [2:0] OP_START_FIRST  = 3'd0;
    localparam logic [2:0] OP_START_NEXT   = 3'd1;
    localparam logic [2:0] OP_START_VERIFY = 3'd2;
    localparam logic [2:0] OP_BIT_PAIR     = 3'd3;
    localparam logic [2:0] OP_TARGET_FAM   = 3'd4;
    localparam logic [2:0] OP_SKIP_FAM     = 3'd5;

    localparam logic [1:0] KIND_CMD  = 2'd0;
    localparam logic [1:0] KIND_DIR  = 2'd1;
    localparam logic [1:0] KIND_DONE = 2'd2;

    localparam logic [7:0] CRC_POLY   = 8'h8C;
    localparam logic [6:0] ROM_BITS   = 7'd64;
    localparam logic [6:0] FAM_LIMIT  = 7'd9;
    localparam int         QUEUE_DEPTH = 4;
    localparam int         QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [2:0] operation;
        logic       presence;
        logic       id_bit;
        logic       cmp_bit;
        logic [7:0] fam_byte;
    } t_req;

    typedef struct packed {
        logic [1:0]  kind;
        logic        direction;
        logic        found;
        logic [63:0] rom_code;
        logic        last_device;
        logic        last;
    } t_res;

    typedef struct packed {
        logic [1:0] cnt;
        t_res       res0;
        t_res       res1;
    } t_push;

    function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

[src/rosrch_core.sv]
// ----------------------------------------------------------------------------
// rosrch_core
// Search state registers and the single-pass update for one operation,
// producing up to two results per accepted transaction.
// ----------------------------------------------------------------------------
module rosrch_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  rosrch_pkg::t_req  i_req,
    output rosrch_pkg::t_push o_push
);

    logic [63:0] r_rom, n_rom;
    logic [6:0]  r_ld, n_ld;
    logic [3:0]  r_lfd, n_lfd;
    logic        r_ldf, n_ldf;
    logic [6:0]  r_pos, n_pos;
    logic [6:0]  r_lzp, n_lzp;
    logic [7:0]  r_crc, n_crc;
    logic        r_search, n_search;
    logic        r_verify, n_verify;
    logic [63:0] r_saved_rom, n_saved_rom;
    logic [11:0] r_saved_disc, n_saved_disc;

    logic        start;
    logic        conc;
    logic        conc_ok;
    logic        dir;
    logic        found;
    logic [6:0]  pos_m1;
    logic [5:0]  idx;
    rosrch_pkg::t_res done_res;

    assign pos_m1 = r_pos - 7'd1;
    assign idx    = pos_m1[5:0];

    always_comb begin
        n_rom        = r_rom;
        n_ld         = r_ld;
        n_lfd        = r_lfd;
        n_ldf        = r_ldf;
        n_pos        = r_pos;
        n_lzp        = r_lzp;
        n_crc        = r_crc;
        n_search     = r_search;
        n_verify     = r_verify;
        n_saved_rom  = r_saved_rom;
        n_saved_disc = r_saved_disc;
        start        = 1'b0;
        conc         = 1'b0;
        conc_ok      = 1'b0;
        dir          = 1'b0;
        found        = 1'b0;
        done_res     = '0;
        o_push       = '0;

        if (i_accept) begin
            unique case (i_req.operation)
                rosrch_pkg::OP_START_FIRST: begin
                    n_verify = 1'b0;
                    n_ld     = '0;
                    n_ldf    = 1'b0;
                    n_lfd    = '0;
                    start    = 1'b1;
                end
                rosrch_pkg::OP_START_NEXT: begin
                    n_verify = 1'b0;
                    start    = 1'b1;
                end
                rosrch_pkg::OP_START_VERIFY: begin
                    n_saved_rom  = r_rom;
                    n_saved_disc = {r_ldf, r_lfd, r_ld};
                    n_ld         = rosrch_pkg::ROM_BITS;
                    n_ldf        = 1'b0;
                    n_verify     = 1'b1;
                    start        = 1'b1;
                end
                rosrch_pkg::OP_BIT_PAIR: begin
                    if (r_search && r_pos >= 7'd1 && r_pos <= rosrch_pkg::ROM_BITS) begin
                        if (i_req.id_bit && i_req.cmp_bit) begin
                            conc = 1'b1;
                        end else begin
                            if (i_req.id_bit != i_req.cmp_bit) begin
                                dir = i_req.id_bit;
                            end else begin
                                if (r_pos < r_ld) begin
                                    dir = r_rom[idx];
                                end else begin
                                    dir = (r_pos == r_ld);
                                end
                                if (!dir) begin
                                    n_lzp = r_pos;
                                    if (r_pos < rosrch_pkg::FAM_LIMIT) begin
                                        n_lfd = r_pos[3:0];
                                    end
                                end
                            end
                            n_rom[idx] = dir;
                            if (r_pos[2:0] == 3'd0) begin
                                n_crc = rosrch_pkg::crc8_byte(r_crc,
                                    n_rom[{pos_m1[5:3], 3'b000} +: 8]);
                            end
                            n_pos                = r_pos + 7'd1;
                            o_push.cnt           = 2'd1;
                            o_push.res0.kind      = rosrch_pkg::KIND_DIR;
                            o_push.res0.direction = dir;
                            o_push.res0.last      = (r_pos != rosrch_pkg::ROM_BITS);
                            if (r_pos == rosrch_pkg::ROM_BITS) begin
                                conc    = 1'b1;
                                conc_ok = (n_crc == 8'd0);
                            end
                        end
                    end
                end
                rosrch_pkg::OP_TARGET_FAM: begin
                    n_search = 1'b0;
                    n_verify = 1'b0;
                    n_rom    = {56'd0, i_req.fam_byte};
                    n_ld     = rosrch_pkg::ROM_BITS;
                    n_lfd    = '0;
                    n_ldf    = 1'b0;
                end
                rosrch_pkg::OP_SKIP_FAM: begin
                    n_search = 1'b0;
                    n_verify = 1'b0;
                    n_ld     = {3'd0, r_lfd};
                    n_lfd    = '0;
                    if (r_lfd == 4'd0) begin
                        n_ldf = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (start) begin
            n_pos    = 7'd1;
            n_lzp    = '0;
            n_crc    = '0;
            n_search = 1'b0;
            if (n_ldf || !i_req.presence) begin
                conc = 1'b1;
            end else begin
                n_search         = 1'b1;
                o_push.cnt       = 2'd1;
                o_push.res0.kind = rosrch_pkg::KIND_CMD;
                o_push.res0.last = 1'b1;
            end
        end

        if (conc) begin
            if (conc_ok) begin
                n_ld = n_lzp;
                if (n_lzp == 7'd0) begin
                    n_ldf = 1'b1;
                end
            end
            if (!conc_ok || n_rom[7:0] == 8'd0) begin
                n_ld  = '0;
                n_ldf = 1'b0;
                n_lfd = '0;
                found = 1'b0;
            end else begin
                found = 1'b1;
            end
            n_search = 1'b0;
            if (n_verify) begin
                found    = found && (n_rom == n_saved_rom);
                n_rom    = n_saved_rom;
                n_ld     = n_saved_disc[6:0];
                n_lfd    = n_saved_disc[10:7];
                n_ldf    = n_saved_disc[11];
                n_verify = 1'b0;
            end
            done_res.kind        = rosrch_pkg::KIND_DONE;
            done_res.found       = found;
            done_res.rom_code    = n_rom;
            done_res.last_device = n_ldf;
            done_res.last        = 1'b1;
            if (o_push.cnt == 2'd0) begin
                o_push.res0 = done_res;
            end else begin
                o_push.res1 = done_res;
            end
            o_push.cnt = o_push.cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom        <= '0;
            r_ld         <= '0;
            r_lfd        <= '0;
            r_ldf        <= 1'b0;
            r_pos        <= 7'd1;
            r_lzp        <= '0;
            r_crc        <= '0;
            r_search     <= 1'b0;
            r_verify     <= 1'b0;
            r_saved_rom  <= '0;
            r_saved_disc <= '0;
        end else begin
            r_rom        <= n_rom;
            r_ld         <= n_ld;
            r_lfd        <= n_lfd;
            r_ldf        <= n_ldf;
            r_pos        <= n_pos;
            r_lzp        <= n_lzp;
            r_crc        <= n_crc;
            r_search     <= n_search;
            r_verify     <= n_verify;
            r_saved_rom  <= n_saved_rom;
            r_saved_disc <= n_saved_disc;
        end
    end

endmodule

[src/rosrch_outq.sv]
// ----------------------------------------------------------------------------
// rosrch_outq
// Small result queue that takes up to two results per cycle and hands one
// transaction per cycle to the output channel while i_stall is low.
// ----------------------------------------------------------------------------
module rosrch_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rosrch_pkg::t_push i_push,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_stall,
    output rosrch_pkg::t_res  o_res
);

    localparam int AW = rosrch_pkg::QUEUE_AW;

    rosrch_pkg::t_res r_mem [rosrch_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [AW:0]      r_cnt, n_cnt;
    logic             pop;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_mem[r_rd];
    assign o_full  = (r_cnt > (AW+1)'(rosrch_pkg::QUEUE_DEPTH - 2));
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_wr  = r_wr + AW'(i_push.cnt);
        n_rd  = r_rd + AW'(pop);
        n_cnt = r_cnt + (AW+1)'(i_push.cnt) - (AW+1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr] <= i_push.res0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[r_wr + AW'(1)] <= i_push.res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[src/onewire_rom_search.sv]
// ----------------------------------------------------------------------------
// onewire_rom_search
// Bus-side 1-Wire ROM search engine with a queued result channel.
// Each result is written into the result queue when its transaction is accepted.
// Throughput: one input transaction per cycle while o_stall is low; a bit pair
// ending a pass yields two results; output drains one per cycle unless stalled.
// Input stalls while the four-entry result queue has fewer than two free slots.
// Reset clears the search state and the queue; bit position resets to one.
// ----------------------------------------------------------------------------
module onewire_rom_search (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    input  rosrch_pkg::t_req i_req,
    output logic             o_valid,
    input  logic             i_stall,
    output rosrch_pkg::t_res o_res
);

    rosrch_pkg::t_push push;
    logic              accept;
    logic              full;

    assign o_stall = full;
    assign accept  = i_valid && !full;

    rosrch_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .o_push   (push)
    );

    rosrch_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (o_res)
    );

endmodule
